[design/lrd_pkg.sv]
`default_nettype none

package lrd_pkg;

  // payload buffer geometry
  localparam int unsigned PAYLOAD_MAX = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned LEN_W       = 11;

  // header layout, as byte counts reached when the field is complete
  localparam int unsigned HEADER_BYTES = 28;
  localparam int unsigned MAGIC_END    = 4;
  localparam int unsigned TYPE_END     = 5;
  localparam int unsigned LENGTH_END   = 12;
  localparam int unsigned SEQ_END      = 20;
  localparam int unsigned CRC_BYTES    = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_END    = 2'd1,
    KIND_BROKEN = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         record_type;
    logic [LEN_W-1:0]   payload_length;
    logic [63:0]        sequence_number;
    logic signed [63:0] time_stamp;
    logic [7:0]         payload_byte;
    logic [31:0]        records_played;
    logic               truncated;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

`default_nettype wire

[design/lrd_ram.sv]
`default_nettype none

module lrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/lrd_parser.sv]
`default_nettype none

module lrd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire lrd_pkg::item_t  item_i,
  input  wire logic [31:0]     magic_i,
  input  wire logic [7:0]      rd_data_i,
  output lrd_pkg::result_t     res_o,
  output logic                 res_vld_o,
  output lrd_pkg::mem_wr_t     wr_o
);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? lrd_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  lrd_pkg::phase_e phase_q, phase_d;
  logic [lrd_pkg::LEN_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0] crc_q, crc_d, crc_next;
  logic [63:0] shift_q, shift_d, shift_w;
  logic [7:0]  type_q, type_d;
  logic [lrd_pkg::LEN_W-1:0] len_q, len_d;
  logic [63:0] seq_q, seq_d;
  logic [63:0] time_q, time_d;
  logic [31:0] rcv_q, rcv_d, rcv_w;
  logic [31:0] count_q, count_d;
  logic        halted_q, halted_d;

  logic take, ev_hdr_done, ev_pay_done, ev_crc_last, ev_rec_ok;

  assign cnt_inc  = cnt_q + lrd_pkg::LEN_W'(1);
  assign shift_w  = {shift_q[55:0], item_i.data_byte};
  assign rcv_w    = {rcv_q[23:0], item_i.data_byte};
  assign crc_next = crc_byte(crc_q, item_i.data_byte);

  assign take        = (item_i.cmd == lrd_pkg::CMD_BYTE) && !halted_q;
  assign ev_hdr_done = take && (phase_q == lrd_pkg::PH_HEADER)
                       && (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::HEADER_BYTES));
  assign ev_pay_done = take && (phase_q == lrd_pkg::PH_PAYLOAD) && (cnt_inc >= len_q);
  assign ev_crc_last = take && (phase_q == lrd_pkg::PH_CRC)
                       && (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::CRC_BYTES));
  assign ev_rec_ok   = ev_crc_last && ((crc_q ^ lrd_pkg::CRC_ONES) == rcv_w);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      lrd_pkg::PH_HEADER: begin
        if (ev_hdr_done) begin
          phase_d = (len_q == '0) ? lrd_pkg::PH_CRC : lrd_pkg::PH_PAYLOAD;
        end
      end
      lrd_pkg::PH_PAYLOAD: begin
        if (ev_pay_done) begin
          phase_d = lrd_pkg::PH_CRC;
        end
      end
      lrd_pkg::PH_CRC: begin
        if (ev_rec_ok) begin
          phase_d = lrd_pkg::PH_HEADER;
        end
      end
      default: phase_d = lrd_pkg::PH_HEADER;
    endcase
  end

  // datapath and result
  always_comb begin
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    shift_d  = shift_q;
    type_d   = type_q;
    len_d    = len_q;
    seq_d    = seq_q;
    time_d   = time_q;
    rcv_d    = rcv_q;
    count_d  = count_q;
    halted_d = halted_q;
    res_o    = '0;
    res_o.records_played = count_q;
    res_vld_o = 1'b0;
    wr_o     = '0;

    case (item_i.cmd)
      lrd_pkg::CMD_BYTE: begin
        if (take) begin
          case (phase_q)
            lrd_pkg::PH_HEADER: begin
              crc_d   = crc_next;
              shift_d = shift_w;
              cnt_d   = cnt_inc;
              if (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::MAGIC_END)) begin
                if (shift_w[31:0] != magic_i) begin
                  halted_d        = 1'b1;
                  res_o.kind      = lrd_pkg::KIND_BROKEN;
                  res_o.truncated = 1'b1;
                  res_vld_o       = 1'b1;
                end
              end else if (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::TYPE_END)) begin
                type_d = item_i.data_byte;
              end else if (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::LENGTH_END)) begin
                if (shift_w[31:0] > 32'(lrd_pkg::PAYLOAD_MAX)) begin
                  halted_d        = 1'b1;
                  res_o.kind      = lrd_pkg::KIND_BROKEN;
                  res_o.truncated = 1'b1;
                  res_vld_o       = 1'b1;
                end else begin
                  len_d = shift_w[lrd_pkg::LEN_W-1:0];
                end
              end else if (cnt_inc == lrd_pkg::LEN_W'(lrd_pkg::SEQ_END)) begin
                seq_d = shift_w;
              end else if (ev_hdr_done) begin
                time_d = shift_w;
                cnt_d  = '0;
                rcv_d  = '0;
              end
            end
            lrd_pkg::PH_PAYLOAD: begin
              crc_d   = crc_next;
              wr_o.en   = advance_i;
              wr_o.addr = cnt_q[lrd_pkg::ADDR_W-1:0];
              wr_o.data = item_i.data_byte;
              cnt_d   = cnt_inc;
              if (ev_pay_done) begin
                cnt_d = '0;
                rcv_d = '0;
              end
            end
            lrd_pkg::PH_CRC: begin
              rcv_d = rcv_w;
              cnt_d = cnt_inc;
              if (ev_crc_last) begin
                if (!ev_rec_ok) begin
                  halted_d        = 1'b1;
                  res_o.kind      = lrd_pkg::KIND_BROKEN;
                  res_o.truncated = 1'b1;
                  res_vld_o       = 1'b1;
                end else begin
                  count_d = (count_q != '1) ? count_q + 32'd1 : count_q;
                  res_o.kind            = lrd_pkg::KIND_ACCEPT;
                  res_o.record_type     = type_q;
                  res_o.payload_length  = len_q;
                  res_o.sequence_number = seq_q;
                  res_o.time_stamp      = $signed(time_q);
                  res_o.records_played  = count_d;
                  res_vld_o             = 1'b1;
                  cnt_d   = '0;
                  crc_d   = lrd_pkg::CRC_ONES;
                  shift_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      lrd_pkg::CMD_END: begin
        res_vld_o = 1'b1;
        if (!halted_q && (phase_q == lrd_pkg::PH_HEADER) && (cnt_q == '0)) begin
          res_o.kind = lrd_pkg::KIND_END;
        end else begin
          halted_d        = 1'b1;
          res_o.kind      = lrd_pkg::KIND_BROKEN;
          res_o.truncated = 1'b1;
        end
      end
      lrd_pkg::CMD_READ: begin
        res_vld_o          = 1'b1;
        res_o.kind         = lrd_pkg::KIND_READ;
        res_o.payload_byte = rd_data_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lrd_pkg::PH_HEADER;
      cnt_q    <= '0;
      crc_q    <= lrd_pkg::CRC_ONES;
      shift_q  <= '0;
      type_q   <= '0;
      len_q    <= '0;
      seq_q    <= '0;
      time_q   <= '0;
      rcv_q    <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      shift_q  <= shift_d;
      type_q   <= type_d;
      len_q    <= len_d;
      seq_q    <= seq_d;
      time_q   <= time_d;
      rcv_q    <= rcv_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

[design/log_record_deframer_crc32_core.sv]
// path: each item is held in the input register, and its result in the result register
// throughput: one item per cycle while the result register is free or being emptied; the crc byte step is combinational
// items that cause no result (stream bytes mid-record, unknown commands) still pass through the input register
// reset: asynchronous, active low; parser state returns to header phase, count and halt clear
// the payload buffer is not cleared by reset and needs no clearing pass
`default_nettype none

module log_record_deframer_crc32_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: expected record magic
  input  wire logic                          cfg_we_i,
  input  wire logic [31:0]                   cfg_wdata_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [lrd_pkg::ADDR_W-1:0]    read_index_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         result_kind_o,
  output logic [7:0]                         record_type_o,
  output logic [lrd_pkg::LEN_W-1:0]          payload_length_o,
  output logic [63:0]                        sequence_number_o,
  output logic signed [63:0]                 time_stamp_o,
  output logic [7:0]                         payload_byte_o,
  output logic [31:0]                        records_played_o,
  output logic                               truncated_o
);

  logic [31:0] magic_q;

  logic            in_valid_q;
  lrd_pkg::item_t  in_item_q;
  logic            out_valid_q;
  lrd_pkg::result_t out_q;

  logic            in_accept;
  logic            advance;
  lrd_pkg::result_t res;
  logic            res_vld;
  lrd_pkg::mem_wr_t wr;

  logic            rd_en;
  logic [7:0]      ram_rdata;
  logic [7:0]      rd_data;
  logic            byp_q;
  logic [7:0]      byp_data_q;

  // the held item moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // magic register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (cfg_we_i) begin
      magic_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= '{cmd:        lrd_pkg::cmd_e'(cmd_i),
                     data_byte:  data_byte_i,
                     read_index: read_index_i};
    end
  end

  // payload buffer: the read is launched on the input transfer so the byte is ready
  // when the item sits in the input register
  assign rd_en = in_accept && (cmd_i == lrd_pkg::CMD_READ);

  lrd_ram #(
    .WIDTH (8),
    .DEPTH (lrd_pkg::PAYLOAD_MAX)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (read_index_i),
    .rdata_o (ram_rdata)
  );

  // a payload byte written on the same edge as the read is launched is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      byp_q      <= wr.en && (wr.addr == read_index_i);
      byp_data_q <= wr.data;
    end
  end

  assign rd_data = byp_q ? byp_data_q : ram_rdata;

  // record parsing, crc and result forming
  lrd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .magic_i   (magic_q),
    .rd_data_i (rd_data),
    .res_o     (res),
    .res_vld_o (res_vld),
    .wr_o      (wr)
  );

  // result register: holds a result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_vld;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.kind;
  assign record_type_o     = out_q.record_type;
  assign payload_length_o  = out_q.payload_length;
  assign sequence_number_o = out_q.sequence_number;
  assign time_stamp_o      = out_q.time_stamp;
  assign payload_byte_o    = out_q.payload_byte;
  assign records_played_o  = out_q.records_played;
  assign truncated_o       = out_q.truncated;

endmodule

`default_nettype wire

[tb/sv/tb_log_record_deframer_crc32_core.sv]
`timescale 1ns / 100ps

module tb_log_record_deframer_crc32_core;
  import lrd_pkg::*;

  // command code the block has no use for; it must be dropped without a result
  localparam logic [1:0] CMD_NONE = 2'd3;
  // stream items in the random part
  localparam int RANDOM_ITEMS = 1700;
  // a result passes the input and result registers after its input transfer, so this covers any item still in flight
  localparam int HOLD_OFF = 4;

  // the block halts for good on any fault, so one run can only close with one of these
  typedef enum int {
    FAULT_MAGIC,
    FAULT_LENGTH,
    FAULT_CRC,
    FAULT_TORN
  } fault_e;

  // tracks the deframer state and queues the result each input transfer should give
  class deframe_tracker;
    logic [31:0]      magic;
    phase_e           phase;
    int unsigned      count;
    logic [31:0]      crc;
    logic [63:0]      shift;
    logic [7:0]       held_type;
    logic [LEN_W-1:0] held_len;
    logic [63:0]      held_seq;
    logic [63:0]      held_stamp;
    logic [31:0]      got_crc;
    logic [7:0]       store [PAYLOAD_MAX];
    logic [31:0]      accepted;
    bit               halted;
    result_t          awaited_results [$];
    int               errors;

    function new();
      magic      = '0;
      phase      = PH_HEADER;
      count      = 0;
      crc        = CRC_ONES;
      shift      = '0;
      held_type  = '0;
      held_len   = '0;
      held_seq   = '0;
      held_stamp = '0;
      got_crc    = '0;
      accepted   = '0;
      halted     = 1'b0;
      errors     = 0;
    endfunction

    // reflected crc-32, one byte at a time
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] v;
      v = c ^ {24'h0, b};
      repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      return v;
    endfunction

    function void take_item(logic [1:0] cmd, logic [7:0] b, logic [ADDR_W-1:0] idx);
      result_t r;
      bit      emit;
      bit      broken;
      r = '0;
      emit = 1'b0;
      broken = 1'b0;
      r.records_played = accepted;
      case (cmd)
        CMD_BYTE: if (!halted) begin
          case (phase)
            PH_HEADER: begin
              crc = crc_step(crc, b);
              shift = {shift[55:0], b};
              count++;
              if (count == MAGIC_END) begin
                broken = (shift[31:0] != magic);
              end else if (count == TYPE_END) begin
                held_type = b;
              end else if (count == LENGTH_END) begin
                if (shift[31:0] > PAYLOAD_MAX) broken = 1'b1;
                else held_len = shift[LEN_W-1:0];
              end else if (count == SEQ_END) begin
                held_seq = shift;
              end else if (count == HEADER_BYTES) begin
                held_stamp = shift;
                count = 0;
                got_crc = '0;
                phase = (held_len == 0) ? PH_CRC : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              crc = crc_step(crc, b);
              store[count] = b;
              count++;
              if (count >= held_len) begin
                count = 0;
                got_crc = '0;
                phase = PH_CRC;
              end
            end
            default: begin
              got_crc = {got_crc[23:0], b};
              count++;
              if (count == CRC_BYTES) begin
                if ((crc ^ CRC_ONES) != got_crc) begin
                  broken = 1'b1;
                end else begin
                  if (accepted != '1) accepted++;
                  emit = 1'b1;
                  r.kind = KIND_ACCEPT;
                  r.record_type = held_type;
                  r.payload_length = held_len;
                  r.sequence_number = held_seq;
                  r.time_stamp = held_stamp;
                  r.records_played = accepted;
                  phase = PH_HEADER;
                  count = 0;
                  crc = CRC_ONES;
                  shift = '0;
                end
              end
            end
          endcase
        end
        CMD_END: begin
          if (!halted && phase == PH_HEADER && count == 0) begin
            emit = 1'b1;
            r.kind = KIND_END;
          end else begin
            broken = 1'b1;
          end
        end
        CMD_READ: begin
          emit = 1'b1;
          r.kind = KIND_READ;
          r.payload_byte = store[idx];
        end
        default: ;
      endcase
      if (broken) begin
        halted = 1'b1;
        emit = 1'b1;
        r.kind = KIND_BROKEN;
        r.truncated = 1'b1;
      end
      if (emit) awaited_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task match_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result of kind %0d with nothing awaited", got.kind));
        return;
      end
      want = awaited_results.pop_front();
      match_field("result_kind", got.kind, want.kind);
      match_field("record_type", got.record_type, want.record_type);
      match_field("payload_length", got.payload_length, want.payload_length);
      match_field("sequence_number", got.sequence_number, want.sequence_number);
      match_field("time_stamp", got.time_stamp, want.time_stamp);
      match_field("payload_byte", got.payload_byte, want.payload_byte);
      match_field("records_played", got.records_played, want.records_played);
      match_field("truncated", got.truncated, want.truncated);
    endtask
  endclass

  // block inputs, known from time zero
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [31:0]       cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic [1:0]        cmd_i        = CMD_BYTE;
  logic [7:0]        data_byte_i  = '0;
  logic [ADDR_W-1:0] read_index_i = '0;
  logic              out_ready_i  = 1'b0;

  // block outputs
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         result_kind_o;
  logic [7:0]         record_type_o;
  logic [LEN_W-1:0]   payload_length_o;
  logic [63:0]        sequence_number_o;
  logic signed [63:0] time_stamp_o;
  logic [7:0]         payload_byte_o;
  logic [31:0]        records_played_o;
  logic               truncated_o;

  deframe_tracker tracker = new();

  int calm_in = 0;     // remaining transfers with no sender gap
  int items_sent = 0;
  int filled = 0;      // payload entries written so far, always a prefix of the buffer
  bit noisy = 1'b0;    // sprinkle reads and dropped commands into records

  log_record_deframer_crc32_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .data_byte_i       (data_byte_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .record_type_o     (record_type_o),
    .payload_length_o  (payload_length_o),
    .sequence_number_o (sequence_number_o),
    .time_stamp_o      (time_stamp_o),
    .payload_byte_o    (payload_byte_o),
    .records_played_o  (records_played_o),
    .truncated_o       (truncated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("log_record_deframer_crc32_core verification failed");
    $finish;
  end

  // cycles to wait before a transfer: a random draw, or none during an occasional run of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // one input transfer; valid stays up for a back-to-back item, payload is only changed after acceptance
  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic [ADDR_W-1:0] idx);
    int gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    data_byte_i <= b;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_item(cmd, b, idx);
    items_sent++;
  endtask

  // either a read of a payload entry already written, or a command the block drops
  task automatic send_noise();
    if (filled > 0 && $urandom_range(0, 1) == 0)
      send_item(CMD_READ, 8'($urandom), ADDR_W'($urandom_range(0, filled - 1)));
    else
      send_item(CMD_NONE, 8'($urandom), ADDR_W'($urandom));
  endtask

  // new magic, only once the block has drained
  task automatic write_magic(logic [31:0] value);
    in_valid_i <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.magic = value;
  endtask

  // builds a framed record and streams the first cut bytes of it (all of it when cut < 0)
  task automatic send_record(logic [31:0] mg, logic [7:0] rec_type, logic [31:0] len_field,
                             int len, logic [63:0] seq, logic [63:0] stamp, bit bad_crc,
                             int cut);
    logic [7:0]  frame [$];
    logic [31:0] crc;
    bit          stores;
    int          pos;
    for (int i = 3; i >= 0; i--) frame.push_back(mg[8*i +: 8]);
    frame.push_back(rec_type);
    repeat (3) frame.push_back(8'($urandom));  // padding, not checked
    for (int i = 3; i >= 0; i--) frame.push_back(len_field[8*i +: 8]);
    for (int i = 7; i >= 0; i--) frame.push_back(seq[8*i +: 8]);
    for (int i = 7; i >= 0; i--) frame.push_back(stamp[8*i +: 8]);
    repeat (len) frame.push_back(8'($urandom));
    crc = CRC_ONES;
    foreach (frame[j]) crc = deframe_tracker::crc_step(crc, frame[j]);
    crc ^= CRC_ONES;
    if (bad_crc) crc ^= 32'(1) << $urandom_range(0, 31);
    for (int i = 3; i >= 0; i--) frame.push_back(crc[8*i +: 8]);
    if (cut < 0 || cut > frame.size()) cut = frame.size();
    // payload reaches the buffer only when the header gets past its checks
    stores = (mg == tracker.magic) && (len_field == len);
    for (int i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_noise();
      send_item(CMD_BYTE, frame[i], '0);
      pos = i - HEADER_BYTES;
      if (stores && pos >= 0 && pos < len && pos + 1 > filled) filled = pos + 1;
    end
  endtask

  // result side: random stalls, each transfer checked against the oldest awaited result
  initial begin : result_sink
    result_t got;
    int      stall;
    int      calm_out;
    calm_out = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    forever begin
      stall = draw_wait(calm_out);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.kind = kind_e'(result_kind_o);
      got.record_type = record_type_o;
      got.payload_length = payload_length_o;
      got.sequence_number = sequence_number_o;
      got.time_stamp = time_stamp_o;
      got.payload_byte = payload_byte_o;
      got.records_played = records_played_o;
      got.truncated = truncated_o;
      tracker.check_result(got);
    end
  end

  initial begin : stimulus
    fault_e fault;
    int     len;
    int     pick;
    int     start;
    int     big_at;
    bit     big_done;
    logic [31:0] len_field;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clean end on an empty stream, a dropped command, field extremes
    send_item(CMD_END, '0, '0);
    send_item(CMD_NONE, 8'hFF, '1);
    // magic still at its reset value, empty payload, all-ones sequence, most negative stamp
    send_record('0, 8'hFF, 32'd0, 0, '1, 64'h8000_0000_0000_0000, 1'b0, -1);
    write_magic(32'hFFFF_FFFF);
    send_record(32'hFFFF_FFFF, 8'h00, 32'd1, 1, '0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, -1);
    send_item(CMD_READ, '0, '0);
    send_record(32'hFFFF_FFFF, 8'hA5, 32'd3, 3, {$urandom, $urandom}, '1, 1'b0, -1);
    // clean end between records keeps the parser going
    send_item(CMD_END, 8'hFF, '1);
    write_magic($urandom);

    // random: mostly well-formed records with noise in between, one record of full size
    noisy = 1'b1;
    start = items_sent;
    big_at = start + $urandom_range(200, 1000);
    big_done = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!big_done && items_sent >= big_at) begin
        send_record(tracker.magic, 8'($urandom), PAYLOAD_MAX, PAYLOAD_MAX,
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, -1);
        send_item(CMD_READ, 8'($urandom), '1);
        big_done = 1'b1;
      end else if (pick < 70) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 3))
            0: write_magic('0);
            1: write_magic('1);
            default: write_magic($urandom);
          endcase
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(0, 24);
        send_record(tracker.magic, 8'($urandom), len, len, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b0, -1);
      end else if (pick < 80) begin
        send_item(CMD_END, 8'($urandom), ADDR_W'($urandom));
      end else begin
        send_noise();
      end
    end

    // closing fault; after it only reads and repeated broken answers remain
    fault = fault_e'($urandom_range(0, 3));
    len = $urandom_range(0, 24);
    case (fault)
      FAULT_MAGIC: begin
        send_record(tracker.magic ^ (32'(1) << $urandom_range(0, 31)), 8'($urandom), len, len,
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, -1);
      end
      FAULT_LENGTH: begin
        len_field = ($urandom_range(0, 1) == 0) ? 32'(PAYLOAD_MAX + 1)
                                                : ($urandom | 32'h8000_0000);
        send_record(tracker.magic, 8'($urandom), len_field, len, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b0, -1);
      end
      FAULT_CRC: begin
        send_record(tracker.magic, 8'($urandom), len, len, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b1, -1);
      end
      default: begin
        // torn record: stream ends somewhere inside it
        send_record(tracker.magic, 8'($urandom), len, len, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b0,
                    $urandom_range(1, HEADER_BYTES + len + CRC_BYTES - 1));
        send_item(CMD_END, '0, '0);
      end
    endcase
    // halted: stream bytes dropped, end answered as broken again, reads still served
    repeat (8) send_item(CMD_BYTE, 8'($urandom), '0);
    send_item(CMD_END, '0, '0);
    repeat (12) send_noise();
    send_item(CMD_END, 8'($urandom), ADDR_W'($urandom));

    // drain, then allow for anything stray
    in_valid_i <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("log_record_deframer_crc32_core verification clean");
    end else begin
      $display("log_record_deframer_crc32_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/lrd_pkg.sv
design/lrd_ram.sv
design/lrd_parser.sv
design/log_record_deframer_crc32_core.sv
tb/sv/tb_log_record_deframer_crc32_core.sv
